### rtl/jhs_pkg.sv
// Package for the Jacobi heat stencil sweep core.
// Sizes, register indexes and the result record. No dependencies.
package jhs_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 13;
  localparam int CFG_BITS    = HEIGHT_BITS;
  localparam int MIN_DIM     = 3;

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int PTR_BITS  = $clog2(OUT_DEPTH);
  localparam int CNT_BITS  = PTR_BITS + 1;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_index_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t value;
    logic    run_last;
    logic    frame_last;
  } result_t;

endpackage

### rtl/jhs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module jhs_ram #(
  parameter int WIDTH     = 32,
  parameter int DEPTH     = 1024,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/jacobi_heat_stencil_sweep_core.sv
// Jacobi heat stencil sweep core: one 4-neighbor averaging pass over a raster grid.
// Depends on jhs_pkg and jhs_ram (two row stores).
//
// Usage:
//  - Input channel (in_valid/in_ready/sample) takes one Q16.16 cell per beat in
//    raster order. Output channel (out_valid/out_ready) gives value, run_last and
//    frame_last. Row 0 comes straight back; row y is emitted while row y+1
//    arrives; row 1 yields nothing; each cell of the last row yields two beats
//    (the cell above, then the border cell itself).
//  - Configuration: cfg_write with cfg_index selects grid_width or grid_height;
//    the value is clamped to the legal range and the frame restarts at cell 0.
//    Write only while idle.
//  - A result enters the result queue with the input beat that completes it.
//  - Throughput: one input beat per cycle while in_ready is high, set by the read
//    of the two row stores (prefetched for the next column) and one 4-operand add.
//    In the last row each input beat pushes two results into the queue.
//  - A 4-entry result queue decouples the sides; input is taken while at
//    least two entries are free, so an output stall backs up into in_ready
//    after at most three more result-pushing beats (row 1 beats push none).
//  - Reset (rst, synchronous) empties the queue, zeroes the counters and sets
//    the grid to 1024 x 1024. Row store contents are not cleared. in_ready is
//    low while rst is high.
module jacobi_heat_stencil_sweep_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [jhs_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [jhs_pkg::SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [jhs_pkg::SAMPLE_BITS-1:0] value,
  output logic                          run_last,
  output logic                          frame_last
);
  import jhs_pkg::*;

  // grid geometry, held as last index
  logic [COL_BITS-1:0] w_last;
  logic [ROW_BITS-1:0] h_last;
  logic [COL_BITS-1:0] w_last_next;
  logic [ROW_BITS-1:0] h_last_next;

  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] row;
  logic [COL_BITS-1:0] col_next;
  logic [ROW_BITS-1:0] row_next;

  // row window for the row being emitted
  sample_t first_cell;
  sample_t center_reg;
  sample_t left_reg;
  sample_t center;
  sample_t up_rd;
  sample_t right_rd;

  logic [COL_BITS-1:0] rd_col;
  logic                accept;
  logic                col_end;

  logic [WIDTH_BITS-1:0]  cfg_w;
  logic [HEIGHT_BITS-1:0] cfg_h;

  logic [SAMPLE_BITS+1:0] sum;
  sample_t                quarter;
  sample_t                stencil;

  result_t entry_a;
  result_t entry_b;
  logic    push_a;
  logic    push_b;
  logic    pop;

  result_t             queue [OUT_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign accept  = in_valid && in_ready;
  assign col_end = (col == w_last);

  // clamp of register writes
  assign cfg_w = cfg_data[WIDTH_BITS-1:0];
  assign cfg_h = cfg_data[HEIGHT_BITS-1:0];

  always_comb begin
    w_last_next = w_last;
    h_last_next = h_last;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_WIDTH: begin
          if (cfg_w < WIDTH_BITS'(MIN_DIM)) begin
            w_last_next = COL_BITS'(MIN_DIM - 1);
          end else if (cfg_w > WIDTH_BITS'(MAX_WIDTH)) begin
            w_last_next = COL_BITS'(MAX_WIDTH - 1);
          end else begin
            w_last_next = COL_BITS'(cfg_w - WIDTH_BITS'(1));
          end
        end
        REG_GRID_HEIGHT: begin
          if (cfg_h < HEIGHT_BITS'(MIN_DIM)) begin
            h_last_next = ROW_BITS'(MIN_DIM - 1);
          end else if (cfg_h > HEIGHT_BITS'(MAX_HEIGHT)) begin
            h_last_next = ROW_BITS'(MAX_HEIGHT - 1);
          end else begin
            h_last_next = ROW_BITS'(cfg_h - HEIGHT_BITS'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // raster position
  always_comb begin
    col_next = col;
    row_next = row;
    if (cfg_write) begin
      col_next = '0;
      row_next = '0;
    end else if (accept) begin
      if (col_end) begin
        col_next = '0;
        row_next = (row == h_last) ? '0 : row + ROW_BITS'(1);
      end else begin
        col_next = col + COL_BITS'(1);
      end
    end
  end

  // stores are read for the position that holds after this edge
  assign rd_col = col_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= COL_BITS'(MAX_WIDTH - 1);
      h_last <= ROW_BITS'(1024 - 1);
      col    <= '0;
      row    <= '0;
    end else begin
      w_last <= w_last_next;
      h_last <= h_last_next;
      col    <= col_next;
      row    <= row_next;
    end
  end

  assign center = (col == '0) ? first_cell : center_reg;

  jhs_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_older (
    .clk   (clk),
    .we    (accept && (row != '0)),
    .waddr (col),
    .wdata (center),
    .raddr (rd_col),
    .rdata (up_rd)
  );

  jhs_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_newer (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (sample),
    .raddr (rd_col + COL_BITS'(1)),
    .rdata (right_rd)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      if (col == '0) begin
        first_cell <= sample;
      end
      left_reg   <= center;
      center_reg <= right_rd;
    end
  end

  // floor of the quarter of the full-width sum always fits
  assign sum = {{2{up_rd[SAMPLE_BITS-1]}}, up_rd}
             + {{2{sample[SAMPLE_BITS-1]}}, sample}
             + {{2{left_reg[SAMPLE_BITS-1]}}, left_reg}
             + {{2{right_rd[SAMPLE_BITS-1]}}, right_rd};
  assign quarter = sum[SAMPLE_BITS+1:2];
  assign stencil = ((col == '0) || col_end) ? center : quarter;

  always_comb begin
    push_a  = accept && (row != ROW_BITS'(1));
    push_b  = accept && (row == h_last);
    entry_a = '{value: stencil, run_last: 1'b1, frame_last: 1'b0};
    if (row == '0) begin
      entry_a.value = sample;
    end
    if (row == h_last) begin
      entry_a.run_last = 1'b0;
    end
    entry_b = '{value: sample, run_last: 1'b1, frame_last: col_end};
  end

  // result queue
  assign in_ready   = !rst && (count <= CNT_BITS'(OUT_DEPTH - 2));
  assign out_valid  = (count != '0);
  assign pop        = out_valid && out_ready;
  assign value      = queue[rd_ptr].value;
  assign run_last   = queue[rd_ptr].run_last;
  assign frame_last = queue[rd_ptr].frame_last;

  always_ff @(posedge clk) begin
    if (push_a) begin
      queue[wr_ptr] <= entry_a;
    end
    if (push_b) begin
      queue[wr_ptr + PTR_BITS'(1)] <= entry_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_a) + PTR_BITS'(push_b);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      count  <= count + CNT_BITS'(push_a) + CNT_BITS'(push_b) - CNT_BITS'(pop);
    end
  end

endmodule
